[hdl/gwm_pkg.sv]
// Shared types and constants for the glob wildcard matcher.
// No dependencies; imported by gwm_cell, glob_wildcard_matcher and the testbench.
package gwm_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned WORD_BYTES = CFG_W / BYTE_W;

  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  // one bit per chain: the running item step and the restart (start set) closure
  typedef struct packed {
    logic step;
    logic start;
  } gwm_chain_t;

endpackage

[hdl/gwm_cell.sv]
// One pattern-position cell: holds the live bit of its position and passes
// star-closure carries to the next cell. Depends on gwm_pkg.
module gwm_cell
  import gwm_pkg::*;
(
  input  logic              clk,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              en,
  input  logic [BYTE_W-1:0] char_code,
  input  logic              fresh,
  input  logic              advance,
  input  gwm_chain_t        carry_in,
  output gwm_chain_t        carry_out,
  output gwm_chain_t        closed
);

  logic live_r;
  logic live_nxt;
  logic is_star;
  logic is_hit;
  logic live_eff;
  logic stay;
  logic adv;

  assign is_star = (pat_byte == STAR_BYTE);
  assign is_hit  = (pat_byte == QMARK_BYTE) || (pat_byte == char_code);

  // start set: only the closure of the position before us
  assign closed.start    = carry_in.start;
  assign carry_out.start = closed.start & en & is_star;

  // a fresh string sees the start set instead of the stored bit
  assign live_eff = fresh ? closed.start : live_r;
  assign stay     = live_eff & en & is_star;
  assign adv      = live_eff & en & is_hit;

  assign closed.step    = stay | carry_in.step;
  assign carry_out.step = adv | (closed.step & en & is_star);

  assign live_nxt = advance ? closed.step : live_r;

  always_ff @(posedge clk) begin
    live_r <= live_nxt;
  end

endmodule

[hdl/glob_wildcard_matcher.sv]
// Glob matcher: one string byte (or empty-string marker) per transaction, one
// match flag per finished string. Takes one item every clock cycle while the
// input is not stalled; star closure ripples combinationally along the cells.
// A result is registered at the output, and input is held only while that
// register is full and stalled. Depends on gwm_pkg and gwm_cell.
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_char_code,
  input  logic                 in_string_end,
  input  logic                 in_string_empty,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_matched
);

  localparam int unsigned NCELL = MAX_PATTERN + 1;
  localparam int unsigned IDX_W = $clog2(NCELL);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_low_nxt;
  logic [CFG_W-1:0] pat_high_r;
  logic [CFG_W-1:0] pat_high_nxt;
  logic             fresh_r;
  logic             fresh_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_matched_r;
  logic             out_matched_nxt;

  logic             cfg_hit;
  logic             load;
  logic             in_acc;
  logic             produce;
  logic             advance;
  logic             match_bit;

  gwm_chain_t       carry [NCELL+1];
  gwm_chain_t       closed [NCELL];

  // ---------------- configuration ----------------
  always_comb begin
    len_nxt      = len_r;
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: begin
          cfg_hit = 1'b1;
          // clamp to the supported pattern size
          if (cfg_wdata[LEN_W-1:0] > LEN_W'(MAX_PATTERN)) begin
            len_nxt = LEN_W'(MAX_PATTERN);
          end else begin
            len_nxt = cfg_wdata[LEN_W-1:0];
          end
        end
        CFG_PATTERN_LOW: begin
          cfg_hit     = 1'b1;
          pat_low_nxt = cfg_wdata;
        end
        CFG_PATTERN_HIGH: begin
          cfg_hit      = 1'b1;
          pat_high_nxt = cfg_wdata;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign load     = !out_valid_r || !out_stall;
  assign in_stall = !load;
  assign in_acc   = in_valid && load;
  assign produce  = in_string_end || in_string_empty;
  assign advance  = in_acc && !produce;

  // ---------------- cell row ----------------
  assign carry[0].step  = 1'b0;
  assign carry[0].start = 1'b1;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [BYTE_W-1:0] pat_byte;
    logic              en;

    if (i < WORD_BYTES) begin : g_low
      assign pat_byte = pat_low_r[i*BYTE_W +: BYTE_W];
    end else if (i < MAX_PATTERN) begin : g_high
      assign pat_byte = pat_high_r[(i-WORD_BYTES)*BYTE_W +: BYTE_W];
    end else begin : g_end
      assign pat_byte = '0;
    end

    assign en = (len_r > LEN_W'(i));

    gwm_cell u_cell (
      .clk       (clk),
      .pat_byte  (pat_byte),
      .en        (en),
      .char_code (in_char_code),
      .fresh     (fresh_r),
      .advance   (advance),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .closed    (closed[i])
    );
  end

  assign match_bit = in_string_empty ? closed[len_r[IDX_W-1:0]].start
                                     : closed[len_r[IDX_W-1:0]].step;

  // ---------------- state update ----------------
  always_comb begin
    fresh_nxt = fresh_r;
    if (cfg_hit) begin
      fresh_nxt = 1'b1;
    end else if (in_acc) begin
      // restart after every finished string
      fresh_nxt = produce;
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (load) begin
      out_valid_nxt   = in_acc && produce;
      out_matched_nxt = match_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pat_low_r   <= pat_low_nxt;
      pat_high_r  <= pat_high_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // ---------------- assertions ----------------
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_string_end || in_string_empty)) |=> out_valid_r)
    else $error("finished string produced no result");

  a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_string_end && !in_string_empty && !out_valid_r)
      |=> !out_valid_r)
    else $error("result invented for a mid-string byte");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_PATTERN_LENGTH || cfg_index == CFG_PATTERN_LOW ||
                cfg_index == CFG_PATTERN_HIGH)) |=> fresh_r)
    else $error("register write did not restart the live set");

  a_empty_matches_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_string_empty && (len_r == '0)) |=> out_matched_r)
    else $error("empty pattern failed to match an empty string");

endmodule

[tb/testbench.sv]
// Testbench for glob_wildcard_matcher: directed and random string streams, checked
// against a bit-level model of the live pattern position set.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL.
module testbench;
  import gwm_pkg::*;

  localparam int unsigned MAX_PAT = 16;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_B = 8'h62;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_char_code = '0;
  logic in_string_end = 1'b0;
  logic in_string_empty = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_matched;

  // model of the matcher
  logic [LEN_W-1:0] pat_len_q;
  logic [CFG_W-1:0] pat_lo_q;
  logic [CFG_W-1:0] pat_hi_q;
  logic [MAX_PAT:0] live_q;
  logic match_flags_q [$];
  logic step_has, step_flag;

  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run = 0;
  int unsigned stall_mode = 0;

  glob_wildcard_matcher #(.MAX_PATTERN(MAX_PAT)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .in_string_end(in_string_end),
    .in_string_empty(in_string_empty),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_matched(out_matched)
  );

  always #5 clk = ~clk;

  function automatic int unsigned used_len();
    return (pat_len_q > MAX_PAT) ? MAX_PAT : int'(pat_len_q);
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(input int unsigned i);
    return (i < WORD_BYTES) ? pat_lo_q[i*BYTE_W +: BYTE_W]
                            : pat_hi_q[(i-WORD_BYTES)*BYTE_W +: BYTE_W];
  endfunction

  function automatic logic [MAX_PAT:0] star_closure(input logic [MAX_PAT:0] s);
    int unsigned n;
    n = used_len();
    for (int unsigned i = 0; i < n; i++)
      if (s[i] && pat_byte(i) == STAR_BYTE) s[i+1] = 1'b1;
    for (int unsigned i = 0; i <= MAX_PAT; i++)
      if (i > n) s[i] = 1'b0;
    return s;
  endfunction

  function automatic logic [MAX_PAT:0] start_set();
    return star_closure({{MAX_PAT{1'b0}}, 1'b1});
  endfunction

  // advance the live set by one transaction; has is set when a string finishes
  function automatic void glob_step(input logic [BYTE_W-1:0] c, input logic e,
                                    input logic m, output logic has,
                                    output logic flag);
    logic [MAX_PAT:0] nxt;
    int unsigned n;
    n = used_len();
    nxt = '0;
    has = 1'b0;
    flag = 1'b0;
    if (m) begin
      live_q = start_set();
      flag = live_q[n];
      has = 1'b1;
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        if (live_q[i]) begin
          if (pat_byte(i) == STAR_BYTE) nxt[i] = 1'b1;
          else if (pat_byte(i) == QMARK_BYTE || pat_byte(i) == c) nxt[i+1] = 1'b1;
        end
      end
      live_q = star_closure(nxt);
      if (e) begin
        flag = live_q[n];
        has = 1'b1;
        live_q = start_set();
      end
    end
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    case (idx)
      CFG_PATTERN_LENGTH: begin
        pat_len_q = data[LEN_W-1:0];
        live_q = start_set();
      end
      CFG_PATTERN_LOW: begin
        pat_lo_q = data;
        live_q = start_set();
      end
      CFG_PATTERN_HIGH: begin
        pat_hi_q = data;
        live_q = start_set();
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic exp_v, input logic act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch at %0t: %s, expected %b, got %b", $time, what, exp_v, act_v);
  endtask

  // results first, then config, then new input: a result never belongs to
  // a transaction taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pat_len_q = '0;
      pat_lo_q = '0;
      pat_hi_q = '0;
      live_q = start_set();
    end else begin
      if (out_valid && !out_stall) begin
        if (match_flags_q.size() == 0) note_mismatch("unexpected result", 1'bx, out_matched);
        else if (out_matched !== match_flags_q[0])
          note_mismatch("matched", match_flags_q[0], out_matched);
        if (match_flags_q.size() != 0) void'(match_flags_q.pop_front());
      end
      if (cfg_we) apply_config(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        glob_step(in_char_code, in_string_end, in_string_empty, step_has, step_flag);
        if (step_has) match_flags_q.push_back(step_flag);
      end
    end
  end

  // receiver stall pattern: stretches of no stall, light, heavy and rare stalls
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(20, 200);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [BYTE_W-1:0] c, input logic e, input logic m);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= c;
    in_string_end <= e;
    in_string_empty <= m;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold the sender until every pending result is out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (match_flags_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_pattern(input logic [CFG_W-1:0] len_word, input logic [CFG_W-1:0] lo,
                              input logic [CFG_W-1:0] hi);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_PATTERN_LENGTH, len_word);
  endtask

  task automatic test_empty_pattern_at_reset();
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(CH_A, 1'b1, 1'b0);
  endtask

  task automatic test_wildcards();
    // zero byte, star, question mark
    load_pattern(64'd3, {40'd0, QMARK_BYTE, STAR_BYTE, 8'h00}, '0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h78, 1'b0, 1'b0);
    send_item(8'h79, 1'b1, 1'b0);
    send_item(QMARK_BYTE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(QMARK_BYTE, 1'b1, 1'b0);
    load_pattern(64'd1, {56'd0, STAR_BYTE}, '0);
    send_item(STAR_BYTE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    load_pattern(64'd1, {56'd0, QMARK_BYTE}, '0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
  endtask

  task automatic test_length_clamp();
    load_pattern('1, {8{STAR_BYTE}}, {8'hFF, {7{STAR_BYTE}}});
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    load_pattern(64'd16, '1, '1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_config_restart();
    load_pattern(64'd2, {48'd0, CH_B, CH_A}, '0);
    send_item(CH_A, 1'b0, 1'b0);
    write_reg(CFG_PATTERN_LOW, {48'd0, CH_B, CH_A});
    send_item(CH_B, 1'b1, 1'b0);
    write_reg(CFG_UNUSED, '1);
    send_item(CH_A, 1'b0, 1'b0);
    send_item(CH_B, 1'b1, 1'b0);
    send_item(CH_A, 1'b0, 1'b0);
    send_item(CH_B, 1'b1, 1'b1);
  endtask

  function automatic logic [BYTE_W-1:0] rand_pat_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_A;
      3: return CH_B;
      4, 5: return STAR_BYTE;
      6, 7: return QMARK_BYTE;
      8: return 8'h00;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_char();
    case ($urandom_range(0, 7))
      0, 1: return CH_A;
      2, 3: return CH_B;
      4: return STAR_BYTE;
      5: return QMARK_BYTE;
      6: return 8'h00;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_strings();
    logic [BYTE_W-1:0] pat [MAX_PAT];
    logic [BYTE_W-1:0] str [$];
    logic [CFG_W-1:0] lo, hi, len_word;
    int unsigned len_reg, eff, start_cnt, phase_start, phase_items, last;
    bit drop_end;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      for (int unsigned i = 0; i < MAX_PAT; i++) pat[i] = rand_pat_byte();
      for (int unsigned i = 0; i < WORD_BYTES; i++) begin
        lo[i*BYTE_W +: BYTE_W] = pat[i];
        hi[i*BYTE_W +: BYTE_W] = pat[i+WORD_BYTES];
      end
      len_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      eff = (len_reg > MAX_PAT) ? MAX_PAT : len_reg;
      len_word = {$urandom(), $urandom()};
      len_word[LEN_W-1:0] = LEN_W'(len_reg);
      load_pattern(len_word, lo, hi);
      if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, {$urandom(), $urandom()});
      phase_start = items_sent;
      phase_items = $urandom_range(30, 90);
      while (items_sent - phase_start < phase_items) begin
        str.delete();
        if ($urandom_range(0, 9) < 7) begin
          // build a string that fits the pattern, then maybe spoil one byte
          for (int unsigned i = 0; i < eff; i++) begin
            if (pat[i] == STAR_BYTE) repeat ($urandom_range(0, 3)) str.push_back(rand_char());
            else if (pat[i] == QMARK_BYTE) str.push_back(rand_char());
            else str.push_back(pat[i]);
          end
          if ($urandom_range(0, 3) == 0 && str.size() != 0)
            str[$urandom_range(0, str.size() - 1)] = rand_char();
        end else begin
          repeat ($urandom_range(0, 12)) str.push_back(rand_char());
        end
        if ($urandom_range(0, 49) == 0) drain_results();
        if (str.size() == 0) begin
          send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          drop_end = ($urandom_range(0, 29) == 0);
          last = str.size() - 1;
          foreach (str[i]) begin
            if (i != last && $urandom_range(0, 39) == 0) begin
              // abandon the string with an empty-string marker
              send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
              break;
            end
            send_item(str[i], (i == last) && !drop_end, 1'b0);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_pattern_at_reset();
    test_wildcards();
    test_length_clamp();
    test_config_restart();
    test_random_strings();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && match_flags_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/gwm_pkg.sv
hdl/gwm_cell.sv
hdl/glob_wildcard_matcher.sv
tb/testbench.sv
